FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the spectral subtraction gain RTL.
// No dependencies; the checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SSG_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SSG_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSG_ASSERT(lbl, clk, rstn, prop, msg)
`define SSG_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/ssg_pkg.sv
// Package for the spectral subtraction gain block: widths, register indexes
// and gain constants. No dependencies.
`default_nettype none
package ssg_pkg;
	localparam int PB_DEFAULT = 32;
	localparam int IN_W       = 32;
	localparam int GAIN_W     = 16;
	localparam int INFL_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 16;
	localparam int GDIV_BITS  = 16;

	localparam logic [GAIN_W-1:0]    UNITY_Q15     = 16'd32768;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SNR_INFL  = 2'd1;
	localparam logic                 MODE_GATE     = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/ssg_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; a sideband word travels with each transaction.
`default_nettype none
module ssg_div_pipe #(
	parameter int VW  = 32,
	parameter int QN  = 48,
	parameter int SBW = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [VW-1:0]  rem_in,
	input  wire logic [QN-1:0]  num_in,
	input  wire logic [VW-1:0]  den_in,
	input  wire logic [SBW-1:0] sb_in,
	output logic                out_valid,
	output logic [QN-1:0]       quo,
	output logic [SBW-1:0]      sb_out
);
	logic           v_s   [1:QN];
	logic [VW-1:0]  rem_s [1:QN];
	logic [QN-1:0]  num_s [1:QN];
	logic [VW-1:0]  den_s [1:QN];
	logic [SBW-1:0] sb_s  [1:QN];

	for (genvar k = 0; k < QN; k++) begin : g_stage
		logic           v_c;
		logic [VW-1:0]  rem_c;
		logic [QN-1:0]  num_c;
		logic [VW-1:0]  den_c;
		logic [SBW-1:0] sb_c;
		logic [VW:0]    full;
		logic [VW:0]    diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_c   = in_valid;
			assign rem_c = rem_in;
			assign num_c = num_in;
			assign den_c = den_in;
			assign sb_c  = sb_in;
		end else begin : g_next
			assign v_c   = v_s[k];
			assign rem_c = rem_s[k];
			assign num_c = num_s[k];
			assign den_c = den_s[k];
			assign sb_c  = sb_s[k];
		end

		assign full = {rem_c, num_c[QN-1]};
		assign diff = full - {1'b0, den_c};
		assign ge   = full >= {1'b0, den_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_c;
			end
		end

		// quotient bits shift in where the dividend bits shift out
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[VW-1:0] : full[VW-1:0];
			num_s[k+1] <= {num_c[QN-2:0], ge};
			den_s[k+1] <= den_c;
			sb_s[k+1]  <= sb_c;
		end
	end

	assign out_valid = v_s[QN];
	assign quo       = num_s[QN];
	assign sb_out    = sb_s[QN];
endmodule
`default_nettype wire

FILE: rtl/core/ssg_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
// Standalone; a sideband word travels with each transaction.
`default_nettype none
module ssg_sqrt_pipe #(
	parameter int RW  = 24,
	parameter int SBW = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [2*RW-1:0] rad_in,
	input  wire logic [SBW-1:0]  sb_in,
	output logic                 out_valid,
	output logic [RW-1:0]        root,
	output logic [SBW-1:0]       sb_out
);
	logic            v_s    [1:RW];
	logic [RW+1:0]   rem_s  [1:RW];
	logic [RW-1:0]   root_s [1:RW];
	logic [2*RW-1:0] rad_s  [1:RW];
	logic [SBW-1:0]  sb_s   [1:RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic            v_c;
		logic [RW+1:0]   rem_c;
		logic [RW-1:0]   root_c;
		logic [2*RW-1:0] rad_c;
		logic [SBW-1:0]  sb_c;
		logic [RW+3:0]   full;
		logic [RW+3:0]   trial;
		logic [RW+3:0]   diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign v_c    = in_valid;
			assign rem_c  = '0;
			assign root_c = '0;
			assign rad_c  = rad_in;
			assign sb_c   = sb_in;
		end else begin : g_next
			assign v_c    = v_s[k];
			assign rem_c  = rem_s[k];
			assign root_c = root_s[k];
			assign rad_c  = rad_s[k];
			assign sb_c   = sb_s[k];
		end

		assign full  = {rem_c, rad_c[2*RW-1 -: 2]};
		assign trial = {2'b00, root_c, 2'b01};
		assign diff  = full - trial;
		assign ge    = full >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[RW+1:0] : full[RW+1:0];
			root_s[k+1] <= {root_c[RW-2:0], ge};
			rad_s[k+1]  <= {rad_c[2*RW-3:0], 2'b00};
			sb_s[k+1]   <= sb_c;
		end
	end

	assign out_valid = v_s[RW];
	assign root      = root_s[RW];
	assign sb_out    = sb_s[RW];
endmodule
`default_nettype wire

FILE: rtl/core/spectral_subtraction_gain_top.sv
// Pipeline: input capture, the bit-per-stage ratio divider and square root, the alpha, product
// and compare registers, the gain divider and an output register.
// Throughput: one bin per cycle, busy is always low; done marks each result cycle.
// Reset clears valid bits and both configuration registers (subtraction, no offset).
`default_nettype none
`include "assert_macros.svh"
module spectral_subtraction_gain_top
	import ssg_pkg::*;
#(
	parameter int POWER_BITS = PB_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [IN_W-1:0]      spectrum_power,
	input  wire logic [IN_W-1:0]      noise_power,
	input  wire logic                 last_bin,
	output logic                      done,
	output logic [GAIN_W-1:0]         gain,
	output logic                      last_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	localparam int P    = POWER_BITS;
	localparam int RW   = P + 16;
	localparam int QW   = (RW + 1) / 2;
	localparam int AW   = QW + 1;
	localparam int TW   = P + 8;
	localparam int MW   = AW + P;
	localparam int SB1  = 2 * P + 1;

	logic              mode_q;
	logic [INFL_W-1:0] infl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			infl_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_MODE: mode_q <= cfg_data[0];
				REG_SNR_INFL:  infl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// input capture
	logic         v_s1;
	logic [P-1:0] s_s1, n_s1;
	logic         last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		s_s1    <= P'(spectrum_power);
		n_s1    <= P'(noise_power);
		last_s1 <= last_bin;
	end

	// ratio S * 2^16 / N
	logic           rdiv_v;
	logic [RW-1:0]  ratio;
	logic [SB1-1:0] rdiv_sb;

	ssg_div_pipe #(.VW(P), .QN(RW), .SBW(SB1)) u_ratio_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.rem_in    ({P{1'b0}}),
		.num_in    ({s_s1, 16'd0}),
		.den_in    (n_s1),
		.sb_in     ({s_s1, n_s1, last_s1}),
		.out_valid (rdiv_v),
		.quo       (ratio),
		.sb_out    (rdiv_sb)
	);

	logic           sq_v;
	logic [QW-1:0]  sq_root;
	logic [SB1-1:0] sq_sb;

	ssg_sqrt_pipe #(.RW(QW), .SBW(SB1)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rdiv_v),
		.rad_in    ((2*QW)'(ratio)),
		.sb_in     (rdiv_sb),
		.out_valid (sq_v),
		.root      (sq_root),
		.sb_out    (sq_sb)
	);

	// alpha in Q.8
	logic          v_a;
	logic [AW-1:0] a_a;
	logic [P-1:0]  s_a, n_a;
	logic          last_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
		end else begin
			v_a <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		a_a    <= (infl_q != '0) ? AW'(infl_q) + AW'(sq_root) : AW'(256);
		s_a    <= sq_sb[SB1-1 -: P];
		n_a    <= sq_sb[P:1];
		last_a <= sq_sb[0];
	end

	// alpha * N
	logic          v_m;
	logic [MW-1:0] an_m;
	logic [P-1:0]  s_m, n_m;
	logic          last_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else begin
			v_m <= v_a;
		end
	end

	always_ff @(posedge clk) begin
		an_m   <= MW'(a_a) * MW'(n_a);
		s_m    <= s_a;
		n_m    <= n_a;
		last_m <= last_a;
	end

	// compare against S * 256 and classify the special cases
	logic          v_c;
	logic [TW-1:0] diff_c;
	logic [P-1:0]  s_c;
	logic          last_c, nzero_c, sge_c, gzero_c;
	logic [MW-1:0] t_ext;

	assign t_ext = MW'({s_m, 8'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c <= 1'b0;
		end else begin
			v_c <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		diff_c  <= TW'(t_ext - an_m);
		s_c     <= s_m;
		last_c  <= last_m;
		nzero_c <= (n_m == '0);
		sge_c   <= (s_m >= n_m);
		gzero_c <= (s_m == '0) || (an_m >= t_ext);
	end

	// (diff * 128) / S
	logic                 gdiv_v;
	logic [GDIV_BITS-1:0] gq;
	logic [3:0]           gdiv_sb;

	ssg_div_pipe #(.VW(P), .QN(GDIV_BITS), .SBW(4)) u_gain_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_c),
		.rem_in    ({1'b0, diff_c[TW-1:9]}),
		.num_in    ({diff_c[8:0], 7'd0}),
		.den_in    (s_c),
		.sb_in     ({last_c, nzero_c, sge_c, gzero_c}),
		.out_valid (gdiv_v),
		.quo       (gq),
		.sb_out    (gdiv_sb)
	);

	logic [GAIN_W-1:0] gain_sel;

	always_comb begin
		if (gdiv_sb[2]) begin
			gain_sel = UNITY_Q15;
		end else if (mode_q == MODE_GATE) begin
			gain_sel = gdiv_sb[1] ? UNITY_Q15 : '0;
		end else if (gdiv_sb[0]) begin
			gain_sel = '0;
		end else begin
			gain_sel = (gq > UNITY_Q15) ? UNITY_Q15 : gq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= gdiv_v;
		end
	end

	always_ff @(posedge clk) begin
		gain     <= gain_sel;
		last_out <= gdiv_sb[3];
	end

	`SSG_ASSERT(a_gain_range, clk, arst_n, done |-> (gain <= UNITY_Q15), "gain above unity")
	`SSG_ASSERT(a_gate_binary, clk, arst_n, done && (mode_q == MODE_GATE) |-> (gain == UNITY_Q15) || (gain == '0), "gating gain not 0 or unity")
	`SSG_ASSERT(a_zero_noise, clk, arst_n, gdiv_v && gdiv_sb[2] |=> done && (gain == UNITY_Q15), "zero threshold did not give unity")
	`SSG_ASSERT_NR(a_never_busy, clk, !busy, "busy raised")
endmodule
`default_nettype wire
